// ===== hdl/sbpf_pkg.sv =====
// Shared types and constants for the spectral band peak finder.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package sbpf_pkg;

    // Default values of the top-level parameters.
    localparam int MAX_POINTS_DEF = 512;
    localparam int POWER_BITS_DEF = 48;

    // Fixed field widths.
    localparam int POWER_W    = 48;
    localparam int SIZE_W     = 4;
    localparam int RATE_W     = 20;
    localparam int IDX_W      = 9;
    localparam int KF_W       = IDX_W + RATE_W;
    localparam int SUM_W      = 57;
    localparam int SHARE_W    = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // Transform size limits, as log2 of the length.
    localparam int SIZE_LOG2_MIN = 2;
    localparam int SIZE_LOG2_TOP = 9;

    // Fraction bits of the peak share, one restoring step each.
    localparam int DIV_STEPS = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LOG2   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_LOW    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_HIGH   = 2'd3;

    // Register reset values.
    localparam logic [SIZE_W-1:0] SIZE_LOG2_RST   = 4'd8;
    localparam logic [RATE_W-1:0] SAMPLE_RATE_RST = 20'd1600;
    localparam logic [RATE_W-1:0] BAND_LOW_RST    = 20'd0;
    localparam logic [RATE_W-1:0] BAND_HIGH_RST   = 20'hFFFFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // take the item and form bin_index * rate
        logic test;      // register the band test
        logic acc;       // update sum, peak and bin index
        logic div_init;  // first quotient bit and peak frequency
        logic div_step;  // one restoring division step
        logic load;      // fill the output register and clear the frame
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_bin;  // current bin closes the frame
        logic out_free;  // output register can take a result this cycle
    } stat_t;

endpackage

`default_nettype wire

// ===== hdl/sbpf_ctrl.sv =====
// Controller state machine for the spectral band peak finder.
// Depends on sbpf_pkg for the command and status structs.
`default_nettype none

module sbpf_ctrl
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire sbpf_pkg::stat_t stat,
    output sbpf_pkg::cmd_t      cmd
);

    localparam int CNT_W = $clog2(sbpf_pkg::DIV_STEPS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TEST,
        S_ACC,
        S_DINIT,
        S_DSTEP,
        S_LOAD
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_TEST;
                    end
                end
                S_TEST:
                begin
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    state_reg <= stat.last_bin ? S_DINIT : S_IDLE;
                end
                S_DINIT:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_DSTEP;
                end
                S_DSTEP:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(sbpf_pkg::DIV_STEPS - 1))
                    begin
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    if (stat.out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        in_stall     = (state_reg != S_IDLE);
        cmd.capture  = (state_reg == S_IDLE) && in_valid;
        cmd.test     = (state_reg == S_TEST);
        cmd.acc      = (state_reg == S_ACC);
        cmd.div_init = (state_reg == S_DINIT);
        cmd.div_step = (state_reg == S_DSTEP);
        cmd.load     = (state_reg == S_LOAD) && stat.out_free;
    end

endmodule

`default_nettype wire

// ===== hdl/sbpf_datapath.sv =====
// Datapath of the spectral band peak finder: registers, band test, running sums,
// peak tracking, restoring divider and output register. Depends on sbpf_pkg.
`default_nettype none

module sbpf_datapath
#(
    parameter int MAX_POINTS = sbpf_pkg::MAX_POINTS_DEF,
    parameter int POWER_BITS = sbpf_pkg::POWER_BITS_DEF
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [sbpf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [sbpf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic [sbpf_pkg::POWER_W-1:0]      power_value,
    input  wire sbpf_pkg::cmd_t                    cmd,
    output sbpf_pkg::stat_t                        stat,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   band_found,
    output logic [sbpf_pkg::RATE_W-1:0]            peak_freq,
    output logic [sbpf_pkg::SUM_W-1:0]             band_energy,
    output logic [sbpf_pkg::SHARE_W-1:0]           peak_share
);

    localparam int SIZE_W  = sbpf_pkg::SIZE_W;
    localparam int RATE_W  = sbpf_pkg::RATE_W;
    localparam int IDX_W   = sbpf_pkg::IDX_W;
    localparam int KF_W    = sbpf_pkg::KF_W;
    localparam int SUM_W   = sbpf_pkg::SUM_W;
    localparam int SHARE_W = sbpf_pkg::SHARE_W;
    localparam int REM_W   = SUM_W + 1;

    // Largest usable size: floor(log2(MAX_POINTS)), kept within the legal range.
    localparam int FLOOR_LOG2 = $clog2(MAX_POINTS + 1) - 1;
    localparam int MAX_LOG2   = (FLOOR_LOG2 > sbpf_pkg::SIZE_LOG2_TOP) ?
                                sbpf_pkg::SIZE_LOG2_TOP :
                                ((FLOOR_LOG2 < sbpf_pkg::SIZE_LOG2_MIN) ?
                                 sbpf_pkg::SIZE_LOG2_MIN : FLOOR_LOG2);

    // Configuration registers.
    logic [SIZE_W-1:0] size_reg;
    logic [RATE_W-1:0] rate_reg;
    logic [RATE_W-1:0] low_reg;
    logic [RATE_W-1:0] high_reg;

    // Frame state.
    logic [IDX_W-1:0]      bin_index_reg;
    logic [SUM_W-1:0]      band_sum_reg;
    logic [POWER_BITS-1:0] peak_level_reg;
    logic [IDX_W-1:0]      peak_index_reg;
    logic                  peak_seen_reg;

    // Per-item and divider working registers.
    logic [POWER_BITS-1:0] p_reg;
    logic [KF_W-1:0]       kf_reg;
    logic                  in_band_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [SHARE_W-1:0]    quo_reg;
    logic [RATE_W-1:0]     freq_reg;

    // Output register.
    logic                  out_valid_reg;
    logic                  band_found_reg;
    logic [RATE_W-1:0]     peak_freq_reg;
    logic [SUM_W-1:0]      band_energy_reg;
    logic [SHARE_W-1:0]    peak_share_reg;

    logic [SIZE_W-1:0] eff_log2;
    logic [IDX_W-1:0]  last_idx;
    logic [IDX_W-1:0]  mul_idx;
    logic [KF_W-1:0]   product;
    logic [KF_W-1:0]   low_n;
    logic [KF_W-1:0]   high_n;
    logic [SUM_W:0]    sum_ext;
    logic [SUM_W-1:0]  sum_next;
    logic [SUM_W-1:0]  peak_ext;
    logic              peak_take;
    logic [REM_W-1:0]  rem_shift;
    logic              found;

    always_comb
    begin
        if (size_reg < SIZE_W'(sbpf_pkg::SIZE_LOG2_MIN))
        begin
            eff_log2 = SIZE_W'(sbpf_pkg::SIZE_LOG2_MIN);
        end
        else if (size_reg > SIZE_W'(MAX_LOG2))
        begin
            eff_log2 = SIZE_W'(MAX_LOG2);
        end
        else
        begin
            eff_log2 = size_reg;
        end
    end

    always_comb
    begin
        last_idx  = IDX_W'(1) << (eff_log2 - 1'b1);
        mul_idx   = cmd.div_init ? peak_index_reg : bin_index_reg;
        product   = KF_W'(mul_idx) * KF_W'(rate_reg);
        low_n     = KF_W'(low_reg) << eff_log2;
        high_n    = KF_W'(high_reg) << eff_log2;
        sum_ext   = (SUM_W + 1)'(band_sum_reg) + (SUM_W + 1)'(p_reg);
        sum_next  = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
        peak_ext  = SUM_W'(peak_level_reg);
        peak_take = !peak_seen_reg || (p_reg > peak_level_reg);
        rem_shift = {rem_reg[REM_W-2:0], 1'b0};
        found     = peak_seen_reg && (band_sum_reg != '0);
    end

    assign stat.last_bin = (bin_index_reg >= last_idx);
    assign stat.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= sbpf_pkg::SIZE_LOG2_RST;
            rate_reg <= sbpf_pkg::SAMPLE_RATE_RST;
            low_reg  <= sbpf_pkg::BAND_LOW_RST;
            high_reg <= sbpf_pkg::BAND_HIGH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sbpf_pkg::CFG_SIZE_LOG2:   size_reg <= cfg_data[SIZE_W-1:0];
                sbpf_pkg::CFG_SAMPLE_RATE: rate_reg <= cfg_data[RATE_W-1:0];
                sbpf_pkg::CFG_BAND_LOW:    low_reg  <= cfg_data[RATE_W-1:0];
                sbpf_pkg::CFG_BAND_HIGH:   high_reg <= cfg_data[RATE_W-1:0];
                default:                   size_reg <= size_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_index_reg  <= '0;
            band_sum_reg   <= '0;
            peak_level_reg <= '0;
            peak_index_reg <= '0;
            peak_seen_reg  <= 1'b0;
        end
        else if (cmd.load)
        begin
            bin_index_reg  <= '0;
            band_sum_reg   <= '0;
            peak_level_reg <= '0;
            peak_index_reg <= '0;
            peak_seen_reg  <= 1'b0;
        end
        else if (cmd.acc)
        begin
            if (in_band_reg)
            begin
                band_sum_reg <= sum_next;
                if (peak_take)
                begin
                    peak_level_reg <= p_reg;
                    peak_index_reg <= bin_index_reg;
                    peak_seen_reg  <= 1'b1;
                end
            end
            if (!stat.last_bin)
            begin
                bin_index_reg <= bin_index_reg + 1'b1;
            end
        end
    end

    // Item capture, band test and divider; these registers need no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            p_reg  <= power_value[POWER_BITS-1:0];
            kf_reg <= product;
        end
        if (cmd.test)
        begin
            in_band_reg <= (kf_reg >= low_n) && (kf_reg <= high_n);
        end
        if (cmd.div_init)
        begin
            freq_reg <= RATE_W'(product >> eff_log2);
            if (peak_ext >= band_sum_reg)
            begin
                quo_reg <= SHARE_W'(1);
                rem_reg <= REM_W'(peak_ext - band_sum_reg);
            end
            else
            begin
                quo_reg <= '0;
                rem_reg <= REM_W'(peak_ext);
            end
        end
        else if (cmd.div_step)
        begin
            if (rem_shift >= REM_W'(band_sum_reg))
            begin
                rem_reg <= rem_shift - REM_W'(band_sum_reg);
                quo_reg <= {quo_reg[SHARE_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                quo_reg <= {quo_reg[SHARE_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            band_found_reg  <= found;
            peak_freq_reg   <= found ? freq_reg : '0;
            band_energy_reg <= found ? band_sum_reg : '0;
            peak_share_reg  <= found ? quo_reg : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign band_found  = band_found_reg;
    assign peak_freq   = peak_freq_reg;
    assign band_energy = band_energy_reg;
    assign peak_share  = peak_share_reg;

endmodule

`default_nettype wire

// ===== hdl/spectral_band_peak_finder_core.sv =====
// Each bin item passes through three states (capture with bin-times-rate multiply,
// band test, accumulate); a new bin is accepted only once the last one is through.
// After a frame's last bin is accepted, its result is formed by the band test,
// accumulate, a set-up state, sixteen restoring division steps and a load state,
// which waits while an earlier result is stalled; the next bin is taken after the load.
// Reset (rst_n low, asynchronous) restores the register defaults and clears the
// frame state and the output valid flag.
`default_nettype none

// Top level of the spectral band peak finder. Instantiates sbpf_ctrl and
// sbpf_datapath; depends on sbpf_pkg.
module spectral_band_peak_finder_core
#(
    parameter int MAX_POINTS = sbpf_pkg::MAX_POINTS_DEF,
    parameter int POWER_BITS = sbpf_pkg::POWER_BITS_DEF
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [sbpf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [sbpf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [sbpf_pkg::POWER_W-1:0]     power_value,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic                                  band_found,
    output logic [sbpf_pkg::RATE_W-1:0]           peak_freq,
    output logic [sbpf_pkg::SUM_W-1:0]            band_energy,
    output logic [sbpf_pkg::SHARE_W-1:0]          peak_share
);

    // The controller sequences each item through the datapath and runs the
    // divider once per frame. It accepts a new item only when idle, while the
    // output register holds a finished result independently, so a stalled
    // result does not hold up the bins of the next frame.
    sbpf_pkg::cmd_t  cmd;
    sbpf_pkg::stat_t stat;

    sbpf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the configuration registers, the frame state (bin
    // index, saturating band sum, first strictly largest peak), the shared
    // index-by-rate multiplier used for both the band test and the peak
    // frequency, and the one-bit-per-cycle restoring divider.
    sbpf_datapath
    #(
        .MAX_POINTS (MAX_POINTS),
        .POWER_BITS (POWER_BITS)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .power_value (power_value),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .band_found  (band_found),
        .peak_freq   (peak_freq),
        .band_energy (band_energy),
        .peak_share  (peak_share)
    );

endmodule

`default_nettype wire

// ===== hdl/sbpf_checker.sv =====
// Port-level checks for the spectral band peak finder, with the bind that
// attaches them to the top level. Depends on sbpf_pkg.
`default_nettype none

module sbpf_checker
(
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             in_valid,
    input wire logic                             in_stall,
    input wire logic                             out_valid,
    input wire logic                             out_stall,
    input wire logic                             band_found,
    input wire logic [sbpf_pkg::RATE_W-1:0]      peak_freq,
    input wire logic [sbpf_pkg::SUM_W-1:0]       band_energy,
    input wire logic [sbpf_pkg::SHARE_W-1:0]     peak_share
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(band_found) &&
        $stable(peak_freq) && $stable(band_energy) && $stable(peak_share))
        else $error("stalled result changed");

    // An accepted item keeps the block busy for its remaining steps.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall ##1 in_stall)
        else $error("item accepted before the previous one finished");

    // A new result is loaded only while the block is busy finishing a frame.
    a_load_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a frame in progress");

    // An empty band gives an all-zero result.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !band_found |->
        peak_freq == '0 && band_energy == '0 && peak_share == '0)
        else $error("empty band result is not zero");

    // A found band has positive power and a share of at most one.
    a_found_sane: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && band_found |->
        band_energy != '0 && peak_share <= sbpf_pkg::SHARE_W'(65536))
        else $error("found band result out of range");

endmodule

bind spectral_band_peak_finder_core sbpf_checker u_sbpf_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .band_found  (band_found),
    .peak_freq   (peak_freq),
    .band_energy (band_energy),
    .peak_share  (peak_share)
);

`default_nettype wire

// ===== sim/spectral_band_peak_finder_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for spectral_band_peak_finder_core: directed frames, then random
// register settings and spectra, each result held to an in-bench model or a typed result.
// Depends on sbpf_pkg and the core RTL only.

module spectral_band_peak_finder_core_test;

    localparam int POWER_W        = sbpf_pkg::POWER_W;
    localparam int SIZE_W         = sbpf_pkg::SIZE_W;
    localparam int RATE_W         = sbpf_pkg::RATE_W;
    localparam int SUM_W          = sbpf_pkg::SUM_W;
    localparam int SHARE_W        = sbpf_pkg::SHARE_W;
    localparam int CFG_IDX_W      = sbpf_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W     = sbpf_pkg::CFG_DATA_W;
    localparam int SIZE_LOG2_MIN  = sbpf_pkg::SIZE_LOG2_MIN;
    localparam int SIZE_LOG2_TOP  = sbpf_pkg::SIZE_LOG2_TOP;
    localparam int MAX_POINTS_DEF = sbpf_pkg::MAX_POINTS_DEF;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LOG2   = sbpf_pkg::CFG_SIZE_LOG2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = sbpf_pkg::CFG_SAMPLE_RATE;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_LOW    = sbpf_pkg::CFG_BAND_LOW;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_HIGH   = sbpf_pkg::CFG_BAND_HIGH;

    // Cycles to let the core settle after the last result before a register write.
    // It covers the steps of a bin and the forming of a result after the last bin of its
    // frame; the rest is margin.
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_BINS   = 840;
    localparam int LONG_HOLD     = 600;
    localparam int MAX_GAP       = 18;

    localparam logic [POWER_W-1:0] POWER_MAX = '1;
    localparam logic [RATE_W-1:0]  EDGE_MAX  = '1;
    localparam logic [63:0]        SUM_LIMIT = (64'd1 << SUM_W) - 64'd1;

    typedef struct packed {
        logic               found;
        logic [RATE_W-1:0]  freq;
        logic [SUM_W-1:0]   power;
        logic [SHARE_W-1:0] share;
    } band_result_t;

    typedef enum logic { ROW_WRITE, ROW_BIN } row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        logic [POWER_W-1:0]     power;
        bit                     typed;
        band_result_t           want;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [POWER_W-1:0]     power_value;
    logic                   out_valid;
    logic                   out_stall;
    logic                   band_found;
    logic [RATE_W-1:0]      peak_freq;
    logic [SUM_W-1:0]       band_energy;
    logic [SHARE_W-1:0]     peak_share;

    spectral_band_peak_finder_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .power_value (power_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .band_found  (band_found),
        .peak_freq   (peak_freq),
        .band_energy (band_energy),
        .peak_share  (peak_share)
    );

    // Copy of the registers as the band model sees them.
    logic [SIZE_W-1:0] cfg_size;
    logic [RATE_W-1:0] cfg_rate;
    logic [RATE_W-1:0] cfg_low;
    logic [RATE_W-1:0] cfg_high;

    // Frame state of the band model.
    int unsigned        frame_pos;
    logic [SUM_W-1:0]   band_acc;
    logic [POWER_W-1:0] top_level;
    int unsigned        top_pos;
    bit                 top_valid;

    band_result_t pending_peaks [$];
    stim_row_t    directed_steps [$];

    int  mismatches;
    int  results_seen;
    int  bins_sent;
    int  frames_closed;
    int  writes_done;
    int  hold_cycles;
    bit  tx_gaps;
    bit  rx_quiet;
    bit  hold_request;

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Sizes below the minimum act as the minimum; larger ones shrink until n fits.
    function automatic int unsigned effective_log2(input logic [SIZE_W-1:0] sz);
        int unsigned s;
        s = sz;
        if (s < SIZE_LOG2_MIN)
            s = SIZE_LOG2_MIN;
        if (s > SIZE_LOG2_TOP)
            s = SIZE_LOG2_TOP;
        while (s > SIZE_LOG2_MIN && (1 << s) > MAX_POINTS_DEF)
            s--;
        return s;
    endfunction

    function automatic int unsigned last_bin_index();
        return (1 << effective_log2(cfg_size)) >> 1;
    endfunction

    // Draws the wait before an item; a brisk side mostly draws no wait.
    function automatic int draw_wait(input bit brisk);
        if (brisk && $urandom_range(0, 3) != 0)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Band model: takes one bin, returns the frame result when the bin closes the frame.
    task automatic advance_band_model(input logic [POWER_W-1:0] p, output bit done,
                                      output band_result_t r);
        int unsigned s;
        logic [63:0] n;
        logic [63:0] kf;
        logic [63:0] pm;
        logic [79:0] scaled;
        s = effective_log2(cfg_size);
        n = 64'd1 << s;
        pm = 64'(p);
        kf = 64'(frame_pos) * 64'(cfg_rate);
        done = 1'b0;
        r = '0;
        if (kf >= 64'(cfg_low) * n && kf <= 64'(cfg_high) * n)
        begin
            if (64'(band_acc) > SUM_LIMIT - pm)
                band_acc = SUM_LIMIT[SUM_W-1:0];
            else
                band_acc = SUM_W'(64'(band_acc) + pm);
            // Only a strictly larger bin takes over, so the first of equal bins stays.
            if (!top_valid || p > top_level)
            begin
                top_level = p;
                top_pos = frame_pos;
                top_valid = 1'b1;
            end
        end
        if (frame_pos < (n >> 1))
        begin
            frame_pos++;
        end
        else
        begin
            done = 1'b1;
            if (top_valid && band_acc != '0)
            begin
                r.found = 1'b1;
                r.freq = RATE_W'((64'(top_pos) * 64'(cfg_rate)) >> s);
                r.power = band_acc;
                scaled = {top_level, 16'h0000};
                r.share = SHARE_W'(scaled / 80'(band_acc));
            end
            frame_pos = 0;
            band_acc = '0;
            top_level = '0;
            top_pos = 0;
            top_valid = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("ERROR result %0d: %s got %0d expected %0d", results_seen, what, got,
                 want);
    endtask

    task automatic compare_result(input band_result_t got);
        band_result_t want;
        results_seen++;
        if (pending_peaks.size() == 0)
        begin
            report_mismatch("result with nothing expected, band_energy", 64'(got.power), 0);
        end
        else
        begin
            want = pending_peaks.pop_front();
            if (got.found !== want.found)
                report_mismatch("band_found", 64'(got.found), 64'(want.found));
            if (got.freq !== want.freq)
                report_mismatch("peak_freq", 64'(got.freq), 64'(want.freq));
            if (got.power !== want.power)
                report_mismatch("band_energy", 64'(got.power), 64'(want.power));
            if (got.share !== want.share)
                report_mismatch("peak_share", 64'(got.share), 64'(want.share));
        end
    endtask

    // Offers one bin, waits for the core to take it, then predicts what it causes.
    task automatic offer_bin(input logic [POWER_W-1:0] p, input int gap, input bit typed,
                             input band_result_t want, output bit closed);
        bit done;
        band_result_t r;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        power_value <= p;
        do @(posedge clk); while (in_stall);
        advance_band_model(p, done, r);
        bins_sent++;
        if (done)
        begin
            pending_peaks.push_back(typed ? want : r);
            frames_closed++;
        end
        closed = done;
    endtask

    // Lowers valid, waits for every expected result, then lets the pipeline empty.
    task automatic settle_block();
        in_valid <= 1'b0;
        while (pending_peaks.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            CFG_SIZE_LOG2:   cfg_size = val[SIZE_W-1:0];
            CFG_SAMPLE_RATE: cfg_rate = val;
            CFG_BAND_LOW:    cfg_low = val;
            CFG_BAND_HIGH:   cfg_high = val;
            default:         ;
        endcase
        writes_done++;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [POWER_W-1:0] draw_power(input logic [POWER_W-1:0] prev);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        else if (r < 20)
            return POWER_MAX;
        else if (r < 30)
            return prev;
        else if (r < 45)
            return POWER_W'($urandom_range(0, 15));
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Sends the rest of the current frame, or only part of it when asked.
    task automatic offer_frame(input bit partial);
        int unsigned remaining;
        int unsigned count;
        bit closed;
        logic [POWER_W-1:0] p;
        band_result_t none;
        none = '0;
        p = '0;
        remaining = (frame_pos <= last_bin_index()) ? last_bin_index() + 1 - frame_pos : 1;
        count = (partial && remaining > 1) ? $urandom_range(1, remaining - 1) : remaining;
        repeat (count)
        begin
            p = draw_power(p);
            offer_bin(p, draw_wait(!tx_gaps), 1'b0, none, closed);
        end
    endtask

    // Random register setting; band edges mostly fall inside the spectrum's span.
    task automatic pick_settings(output logic [SIZE_W-1:0] sz, output logic [RATE_W-1:0] rate,
                                 output logic [RATE_W-1:0] lo, output logic [RATE_W-1:0] hi);
        int r;
        int unsigned half;
        r = $urandom_range(0, 99);
        if (r < 55)
            sz = SIZE_W'($urandom_range(2, 3));
        else if (r < 75)
            sz = SIZE_W'($urandom_range(4, 5));
        else if (r < 85)
            sz = SIZE_W'($urandom_range(0, 1));
        else if (r < 92)
            sz = SIZE_W'($urandom_range(6, 7));
        else if (r < 96)
            sz = SIZE_W'(8);
        else
            sz = SIZE_W'($urandom_range(9, 15));
        r = $urandom_range(0, 99);
        if (r < 8)
            rate = '0;
        else if (r < 16)
            rate = EDGE_MAX;
        else if (r < 30)
            rate = RATE_W'($urandom_range(1, 4096));
        else
            rate = RATE_W'($urandom);
        half = rate / 2;
        r = $urandom_range(0, 99);
        if (r < 25)
            lo = '0;
        else if (r < 32)
            lo = EDGE_MAX;
        else
            lo = RATE_W'($urandom_range(0, half));
        r = $urandom_range(0, 99);
        if (r < 20)
            hi = EDGE_MAX;
        else if (r < 27)
            hi = '0;
        else if (r < 35)
            hi = lo;
        else
            hi = RATE_W'($urandom_range(lo, (half > lo) ? half : lo));
    endtask

    function automatic stim_row_t row_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] val);
        stim_row_t row;
        row = '{ROW_WRITE, idx, val, '0, 1'b0, '0};
        return row;
    endfunction

    function automatic stim_row_t row_bin(input logic [POWER_W-1:0] p);
        stim_row_t row;
        row = '{ROW_BIN, CFG_SIZE_LOG2, '0, p, 1'b0, '0};
        return row;
    endfunction

    function automatic stim_row_t row_bin_want(input logic [POWER_W-1:0] p,
                                               input band_result_t want);
        stim_row_t row;
        row = '{ROW_BIN, CFG_SIZE_LOG2, '0, p, 1'b1, want};
        return row;
    endfunction

    // Directed frames. With size 2 a frame is three bins; each group below closes one
    // frame, and only the last bin of a group can carry a typed result.
    task automatic build_directed_steps();
        // Reset rate (1600 Hz) and full band: all-zero power gives an all-zero result.
        directed_steps.push_back(row_write(CFG_SIZE_LOG2, 20'd2));
        directed_steps.push_back(row_bin(48'd0));
        directed_steps.push_back(row_bin(48'd0));
        directed_steps.push_back(row_bin_want(48'd0, '0));
        // Equal powers: the first of the two stays the peak.
        directed_steps.push_back(row_bin(48'd5));
        directed_steps.push_back(row_bin(48'd5));
        directed_steps.push_back(row_bin(48'd3));
        // Full-scale bins throughout.
        directed_steps.push_back(row_bin(POWER_MAX));
        directed_steps.push_back(row_bin(POWER_MAX));
        directed_steps.push_back(row_bin(POWER_MAX));
        // The whole band power sits in the top bin: share is exactly one.
        directed_steps.push_back(row_bin(48'd0));
        directed_steps.push_back(row_bin(48'd0));
        directed_steps.push_back(row_bin_want(POWER_MAX,
            '{1'b1, 20'd800, SUM_W'(POWER_MAX), 17'd65536}));
        // Band above the spectrum: empty band.
        directed_steps.push_back(row_write(CFG_BAND_LOW, EDGE_MAX));
        directed_steps.push_back(row_write(CFG_BAND_HIGH, EDGE_MAX));
        directed_steps.push_back(row_bin(48'd7));
        directed_steps.push_back(row_bin(48'd8));
        directed_steps.push_back(row_bin_want(48'd9, '0));
        // Band of zero width at DC with the largest rate: only bin 0 counts.
        directed_steps.push_back(row_write(CFG_SAMPLE_RATE, EDGE_MAX));
        directed_steps.push_back(row_write(CFG_BAND_LOW, 20'd0));
        directed_steps.push_back(row_write(CFG_BAND_HIGH, 20'd0));
        directed_steps.push_back(row_bin(48'd9));
        directed_steps.push_back(row_bin(POWER_MAX));
        directed_steps.push_back(row_bin_want(POWER_MAX,
            '{1'b1, 20'd0, SUM_W'(9), 17'd65536}));
        // Size below the minimum acts as the minimum; the peak frequency truncates.
        directed_steps.push_back(row_write(CFG_SIZE_LOG2, 20'd0));
        directed_steps.push_back(row_write(CFG_BAND_HIGH, EDGE_MAX));
        directed_steps.push_back(row_bin(48'd1));
        directed_steps.push_back(row_bin(48'd2));
        directed_steps.push_back(row_bin(48'd3));
        // Size shrinks mid-frame: the next bin lies past the new last bin and closes it.
        directed_steps.push_back(row_write(CFG_SIZE_LOG2, 20'd3));
        directed_steps.push_back(row_bin(48'd4));
        directed_steps.push_back(row_bin(48'd6));
        directed_steps.push_back(row_bin(48'd6));
        directed_steps.push_back(row_write(CFG_SIZE_LOG2, 20'd2));
        directed_steps.push_back(row_bin(48'd2));
    endtask

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("Timed out with %0d results still expected", pending_peaks.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: waits a drawn number of cycles with stall high before each item,
    // or holds off for a long stretch when the stimulus asks for it.
    initial
    begin : result_sink
        int w;
        band_result_t got;
        out_stall <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (hold_request)
            begin
                w = LONG_HOLD;
                hold_request = 1'b0;
                hold_cycles += w;
            end
            else
            begin
                w = draw_wait(rx_quiet);
            end
            if (w != 0)
            begin
                out_stall <= 1'b1;
                repeat (w) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
            got.found = band_found;
            got.freq = peak_freq;
            got.power = band_energy;
            got.share = peak_share;
            compare_result(got);
        end
    end

    // Stimulus: reset, directed steps, a long output hold, then random settings.
    initial
    begin : stimulus
        bit closed;
        int guard;
        int rand_start;
        int frames;
        logic [SIZE_W-1:0] sz;
        logic [RATE_W-1:0] rate;
        logic [RATE_W-1:0] lo;
        logic [RATE_W-1:0] hi;

        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_SIZE_LOG2;
        cfg_data <= '0;
        in_valid <= 1'b0;
        power_value <= '0;
        cfg_size = sbpf_pkg::SIZE_LOG2_RST;
        cfg_rate = sbpf_pkg::SAMPLE_RATE_RST;
        cfg_low = sbpf_pkg::BAND_LOW_RST;
        cfg_high = sbpf_pkg::BAND_HIGH_RST;
        frame_pos = 0;
        band_acc = '0;
        top_level = '0;
        top_pos = 0;
        top_valid = 1'b0;
        mismatches = 0;
        results_seen = 0;
        bins_sent = 0;
        frames_closed = 0;
        writes_done = 0;
        hold_cycles = 0;
        tx_gaps = 1'b1;
        rx_quiet = 1'b0;
        hold_request = 1'b0;
        build_directed_steps();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_steps[i])
        begin
            if (directed_steps[i].kind == ROW_WRITE)
            begin
                settle_block();
                write_reg(directed_steps[i].reg_idx, directed_steps[i].reg_val);
            end
            else
            begin
                offer_bin(directed_steps[i].power, $urandom_range(0, MAX_GAP),
                          directed_steps[i].typed, directed_steps[i].want, closed);
            end
        end

        // Output held off while frames keep coming with few gaps, so the core's result
        // register fills and the input has to stall.
        settle_block();
        write_reg(CFG_SIZE_LOG2, 20'd2);
        tx_gaps = 1'b0;
        rx_quiet = 1'b1;
        hold_request = 1'b1;
        repeat (24) offer_frame(1'b0);

        rand_start = bins_sent;
        while (bins_sent - rand_start < RANDOM_BINS)
        begin
            pick_settings(sz, rate, lo, hi);
            settle_block();
            write_reg(CFG_SIZE_LOG2, CFG_DATA_W'(sz));
            write_reg(CFG_SAMPLE_RATE, rate);
            write_reg(CFG_BAND_LOW, lo);
            write_reg(CFG_BAND_HIGH, hi);
            tx_gaps = ($urandom_range(0, 3) != 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            frames = $urandom_range(1, 4);
            for (int f = 0; f < frames && bins_sent - rand_start < RANDOM_BINS; f++)
                offer_frame(f == frames - 1 && $urandom_range(0, 6) == 0);
        end

        // Close any frame left open so that nothing is pending in the core's state.
        if (frame_pos != 0)
            offer_frame(1'b0);
        in_valid <= 1'b0;
        guard = 0;
        while (pending_peaks.size() != 0 && guard < 50_000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_peaks.size() != 0)
            report_mismatch("results never arrived, count", 64'(pending_peaks.size()), 0);

        $display("Run sent %0d bins in %0d frames over %0d register writes,",
                 bins_sent, frames_closed, writes_done);
        $display("held output %0d cycles and checked %0d results, %0d field mismatches.",
                 hold_cycles, results_seen, mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
